FILE: sv/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants for the max tournament tree.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SCN_RD = 7'b0000100,
    ST_SCN_WR = 7'b0001000,
    ST_BLD_RD = 7'b0010000,
    ST_BLD_WR = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } mtt_state_t;

  typedef logic signed [DATA_W-1:0] mtt_data_t;

endpackage

FILE: sv/max_tournament_tree.sv
// ----------------------------------------------------------------------------
// max_tournament_tree
// Max winner tree over LEAVES leaves, kept in one heap-ordered memory and
// rebuilt by a single shared signed comparator under a small sequencer.
//
//   channel | ports                                        | flow
//   input   | start, busy, in_kind, in_value               | start & !busy
//   result  | out_valid, out_winner, out_taken_value,      | one-cycle strobe
//           | out_rejected, out_full_res                   |
//
// Add that does not fill the tree, or add when full: result in the next cycle.
// Add that fills the tree: rebuild, a read and a write state per node.
// Take: leaf scan (a read and a write state per leaf), then rebuild.
// After reset a clearing pass zeroes the memory; busy stays high meanwhile.
// The receiver takes every strobe; nothing stalls it.
// ----------------------------------------------------------------------------
module max_tournament_tree
  import mtt_pkg::*;
#(
  parameter int unsigned LEAVES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_winner,
  output logic signed [DATA_W-1:0] out_taken_value,
  output logic                     out_rejected,
  output logic                     out_full_res
);

  localparam int unsigned NODES = 2 * LEAVES - 1;
  localparam int unsigned CW    = $clog2(LEAVES);
  localparam int unsigned IW    = CW + 1;
  localparam int unsigned CNTW  = $clog2(LEAVES + 1);

  mtt_data_t mem_r [NODES];

  mtt_state_t      state_r, state_nxt;
  logic [IW-1:0]   clr_r, clr_nxt;
  logic [CW-1:0]   node_i_r, node_i_nxt;
  logic [CW-1:0]   leaf_k_r, leaf_k_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  mtt_data_t       root_r, root_nxt;
  mtt_data_t       taken_r, taken_nxt;
  logic            rej_r, rej_nxt;
  mtt_data_t       rd_a_r, rd_b_r;

  logic            ov_r, ov_nxt;
  mtt_data_t       owin_r, owin_nxt;
  mtt_data_t       otak_r, otak_nxt;
  logic            orej_r, orej_nxt;
  logic            ofull_r, ofull_nxt;

  logic            we;
  logic [IW-1:0]   wa, ra, rb;
  mtt_data_t       wd, best;
  logic [IW-1:0]   left_a, right_a, scan_a, fill_a;
  logic            accept, full;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign full    = (cnt_r == CNTW'(LEAVES));
  assign left_a  = {node_i_r, 1'b1};
  assign right_a = left_a + IW'(1);
  assign scan_a  = IW'(LEAVES - 1) + IW'(leaf_k_r);
  assign fill_a  = IW'(LEAVES - 1) + IW'(cnt_r[CW-1:0]);
  assign best    = (rd_a_r > rd_b_r) ? rd_a_r : rd_b_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    node_i_nxt = node_i_r;
    leaf_k_nxt = leaf_k_r;
    cnt_nxt    = cnt_r;
    root_nxt   = root_r;
    taken_nxt  = taken_r;
    rej_nxt    = rej_r;
    ov_nxt     = 1'b0;
    owin_nxt   = owin_r;
    otak_nxt   = otak_r;
    orej_nxt   = orej_r;
    ofull_nxt  = ofull_r;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    ra         = left_a;
    rb         = right_a;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        if (clr_r == IW'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_TAKE) begin
            taken_nxt  = root_r;
            rej_nxt    = 1'b0;
            leaf_k_nxt = '0;
            state_nxt  = ST_SCN_RD;
          end else if (full) begin
            ov_nxt    = 1'b1;
            owin_nxt  = root_r;
            otak_nxt  = '0;
            orej_nxt  = 1'b1;
            ofull_nxt = 1'b1;
          end else begin
            we        = 1'b1;
            wa        = fill_a;
            wd        = in_value;
            cnt_nxt   = cnt_r + CNTW'(1);
            taken_nxt = '0;
            rej_nxt   = 1'b0;
            if (cnt_r == CNTW'(LEAVES - 1)) begin
              node_i_nxt = CW'(LEAVES - 2);
              state_nxt  = ST_BLD_RD;
            end else begin
              ov_nxt    = 1'b1;
              owin_nxt  = root_r;
              otak_nxt  = '0;
              orej_nxt  = 1'b0;
              ofull_nxt = 1'b0;
            end
          end
        end
      end
      ST_SCN_RD: begin
        ra        = scan_a;
        state_nxt = ST_SCN_WR;
      end
      ST_SCN_WR: begin
        if (rd_a_r == taken_r) begin
          we = 1'b1;
          wa = scan_a;
        end
        if (leaf_k_r == CW'(LEAVES - 1)) begin
          node_i_nxt = CW'(LEAVES - 2);
          state_nxt  = ST_BLD_RD;
        end else begin
          leaf_k_nxt = leaf_k_r + CW'(1);
          state_nxt  = ST_SCN_RD;
        end
      end
      ST_BLD_RD: begin
        state_nxt = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        we = 1'b1;
        wa = IW'(node_i_r);
        wd = best;
        if (node_i_r == '0) begin
          root_nxt  = best;
          ov_nxt    = 1'b1;
          owin_nxt  = best;
          otak_nxt  = taken_r;
          orej_nxt  = rej_r;
          ofull_nxt = full;
          state_nxt = ST_IDLE;
        end else begin
          node_i_nxt = node_i_r - CW'(1);
          state_nxt  = ST_BLD_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      root_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      root_r  <= root_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_i_r <= node_i_nxt;
    leaf_k_r <= leaf_k_nxt;
    taken_r  <= taken_nxt;
    rej_r    <= rej_nxt;
    owin_r   <= owin_nxt;
    otak_r   <= otak_nxt;
    orej_r   <= orej_nxt;
    ofull_r  <= ofull_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_a_r <= mem_r[ra];
    rd_b_r <= mem_r[rb];
  end

  assign out_valid       = ov_r;
  assign out_winner      = owin_r;
  assign out_taken_value = otak_r;
  assign out_rejected    = orej_r;
  assign out_full_res    = ofull_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(LEAVES))
    else $error("leaf count beyond LEAVES");

  a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && orej_r |-> ofull_r)
    else $error("rejected add without a full tree");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $past(state_r) == ST_IDLE || $past(state_r) == ST_BLD_WR)
    else $error("result strobe from unexpected state");

  a_root_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BLD_WR && node_i_r == '0 |=> ov_r && root_r == owin_r)
    else $error("root not published at end of rebuild");

endmodule

FILE: verif/tb_max_tournament_tree.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_tournament_tree
// Self-checking bench for the max tournament tree. Drives adds and takes
// through the start/busy handshake with random gaps, keeps its own copy of
// the leaves and internal nodes, and compares every result strobe with the
// oldest predicted result. Directed cases cover the extremes and the special
// cases; random traffic runs both with gaps and back to back.
// ----------------------------------------------------------------------------
module tb_max_tournament_tree;
  import mtt_pkg::*;

  localparam int unsigned LEAVES      = 8;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct {
    mtt_data_t winner;
    mtt_data_t taken;
    logic      rejected;
    logic      full;
  } tree_result_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  logic      in_kind;
  mtt_data_t in_value;
  logic      out_valid;
  mtt_data_t out_winner;
  mtt_data_t out_taken_value;
  logic      out_rejected;
  logic      out_full_res;

  mtt_data_t    tree_leaf [LEAVES];
  mtt_data_t    tree_node [LEAVES-1];
  int unsigned  filled_cnt;
  tree_result_t pending_results [$];

  bit idle_on;
  int cycle_cnt;
  int err_cnt;
  int sent_cnt;
  int checked_cnt;
  int take_cnt;
  int reject_cnt;

  max_tournament_tree #(.LEAVES(LEAVES)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_winner      (out_winner),
    .out_taken_value (out_taken_value),
    .out_rejected    (out_rejected),
    .out_full_res    (out_full_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mtt_data_t child_val(input int unsigned idx);
    if (idx < LEAVES - 1) return tree_node[idx];
    return tree_leaf[idx - (LEAVES - 1)];
  endfunction

  function automatic void rebuild_nodes();
    mtt_data_t lv;
    mtt_data_t rv;
    int        i;
    for (i = LEAVES - 2; i >= 0; i--) begin
      lv = child_val(2 * i + 1);
      rv = child_val(2 * i + 2);
      tree_node[i] = (lv > rv) ? lv : rv;
    end
  endfunction

  function automatic tree_result_t predict_tree_step(input logic kind, input mtt_data_t value);
    tree_result_t r;
    int           k;
    r.taken    = '0;
    r.rejected = 1'b0;
    if (kind == KIND_ADD) begin
      if (filled_cnt >= LEAVES) begin
        r.rejected = 1'b1;
      end else begin
        tree_leaf[filled_cnt] = value;
        filled_cnt++;
      end
      if (filled_cnt >= LEAVES) rebuild_nodes();
    end else begin
      r.taken = tree_node[0];
      for (k = 0; k < LEAVES; k++) begin
        if (tree_leaf[k] == r.taken) tree_leaf[k] = '0;
      end
      rebuild_nodes();
    end
    r.winner = tree_node[0];
    r.full   = (filled_cnt >= LEAVES);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input mtt_data_t got, input mtt_data_t want);
    err_cnt++;
    $display("[%0t] mismatch %s: got %0d (0x%08h), want %0d (0x%08h)",
             $time, what, got, got, want, want);
  endtask

  // one input transfer; start stays high when the next item follows at once
  task automatic send_item(input logic kind, input mtt_data_t value);
    tree_result_t r;
    if (idle_on) begin
      while ($urandom_range(99) < 38) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_tree_step(kind, value);
    pending_results.push_back(r);
    sent_cnt++;
    if (kind == KIND_TAKE) take_cnt++;
    if (r.rejected) reject_cnt++;
  endtask

  function automatic mtt_data_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4:       return tree_leaf[$urandom_range(LEAVES - 1)];
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin : result_check
    tree_result_t want_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, winner", out_winner, '0);
      end else begin
        want_r = pending_results.pop_front();
        checked_cnt++;
        if (out_winner !== want_r.winner)
          report_mismatch("winner", out_winner, want_r.winner);
        if (out_taken_value !== want_r.taken)
          report_mismatch("taken_value", out_taken_value, want_r.taken);
        if (out_rejected !== want_r.rejected)
          report_mismatch("rejected", DATA_W'(out_rejected), DATA_W'(want_r.rejected));
        if (out_full_res !== want_r.full)
          report_mismatch("full_res", DATA_W'(out_full_res), DATA_W'(want_r.full));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_take_on_empty();
    send_item(KIND_TAKE, 32'sh7FFF_FFFF);
  endtask

  // takes before the tree is full zero the unfilled leaves too
  task automatic test_partial_take();
    send_item(KIND_ADD, 32'sd5);
    send_item(KIND_ADD, -32'sd3);
    send_item(KIND_TAKE, '0);
    send_item(KIND_TAKE, -32'sd1);
  endtask

  task automatic test_fill_extremes();
    send_item(KIND_ADD, 32'sh7FFF_FFFF);
    send_item(KIND_ADD, 32'sh8000_0000);
    send_item(KIND_ADD, 32'sh7FFF_FFFF);
    send_item(KIND_ADD, -32'sd1);
    send_item(KIND_ADD, 32'sd1);
    send_item(KIND_ADD, 32'sh5555_5555);
  endtask

  task automatic test_add_when_full();
    send_item(KIND_ADD, 32'sh1234_5678);
    send_item(KIND_ADD, 32'shAAAA_AAAA);
  endtask

  // duplicate maxima leave together; a drained tree keeps a zero root
  task automatic test_take_duplicates();
    repeat (6) send_item(KIND_TAKE, $urandom);
  endtask

  task automatic test_random_traffic(input int n_items);
    repeat (n_items) begin
      if ($urandom_range(1)) send_item(KIND_TAKE, $urandom);
      else send_item(KIND_ADD, pick_value());
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    idle_on = 1'b0;
    test_random_traffic(n_items);
    idle_on = 1'b1;
  endtask

  initial begin
    int k;
    for (k = 0; k < LEAVES; k++) tree_leaf[k] = '0;
    for (k = 0; k < LEAVES - 1; k++) tree_node[k] = '0;
    filled_cnt  = 0;
    idle_on     = 1'b1;
    cycle_cnt   = 0;
    err_cnt     = 0;
    sent_cnt    = 0;
    checked_cnt = 0;
    take_cnt    = 0;
    reject_cnt  = 0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_kind  <= KIND_ADD;
    in_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_take_on_empty();
    test_partial_take();
    test_fill_extremes();
    test_add_when_full();
    test_take_duplicates();
    test_random_traffic(300);
    test_back_to_back(300);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d items (%0d takes, %0d adds refused on a full tree)",
             sent_cnt, take_cnt, reject_cnt);
    $display("Checked %0d results, %0d mismatches", checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mtt_pkg.sv
sv/max_tournament_tree.sv
verif/tb_max_tournament_tree.sv
